### hw/rtl/dvru_pkg.sv
// ----------------------------------------------------------------------------
// dvru_pkg
// Shared constants for the distance-vector route update unit: table size,
// cost and next-hop codes, item kinds.
// ----------------------------------------------------------------------------
package dvru_pkg;

   localparam int NODES  = 8;
   localparam int NODE_W = (NODES > 1) ? $clog2(NODES) : 1;

   localparam int COST_W = 16;
   localparam int HOP_W  = 4;
   localparam int ENTRY_W = COST_W + HOP_W;

   localparam logic signed [COST_W-1:0] COST_UNREACH = -16'sd1;
   localparam logic signed [COST_W-1:0] COST_SELF    = -16'sd2;
   localparam logic signed [COST_W-1:0] COST_MAX     = 16'sd32767;
   localparam logic signed [HOP_W-1:0]  HOP_UNKNOWN  = -4'sd1;
   localparam logic signed [HOP_W-1:0]  HOP_SELF     = -4'sd2;

   localparam logic [7:0] IDLE_MAX = 8'd255;

   localparam logic [1:0] KIND_LOAD = 2'd0;
   localparam logic [1:0] KIND_ADV  = 2'd1;
   localparam logic [1:0] KIND_LOOK = 2'd2;

endpackage

### hw/rtl/distance_vector_route_update_unit.sv
// ----------------------------------------------------------------------------
// distance_vector_route_update_unit
// Per-destination routing table (cost, next hop) with Bellman-Ford updates.
// ----------------------------------------------------------------------------
// Usage:
//   csr_*  : write channel for own_index; always ready, write only when idle.
//   req_*  : one item per handshake: load link entry, advertised vector
//            element or lookup. Accepted when req_valid high, req_stall low.
//   rsp_*  : one result item per request, reporting the entry named by dest
//            after the item is applied, plus round flag and idle-round count.
// Item flow:
//   An accepted item reads the sender and dest entries from the route
//   memory (registered read), then is applied and written back in the
//   execute state once the output register is not held by rsp_stall,
//   while its result is loaded into the output register. No new item is
//   accepted until the last one is applied: req_stall is high in execute.
// Reset:
//   Synchronous, active high. All entries read as unreachable/unknown,
//   round flag and idle counter clear, own_index is 0. No clearing pass.
// Stall:
//   The output register holds while rsp_stall is high; one further item
//   may be accepted and read, then req_stall stays high until it drains.
// ----------------------------------------------------------------------------
module distance_vector_route_update_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_own_index,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [2:0]  req_sender,
   input  logic [2:0]  req_dest,
   input  logic signed [15:0] req_cost,
   input  logic        req_is_neighbour,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_dest_out,
   output logic signed [15:0] rsp_cost_out,
   output logic signed [3:0]  rsp_next_hop,
   output logic        rsp_changed,
   output logic        rsp_round_updated,
   output logic [7:0]  rsp_idle_rounds
);

   typedef enum logic {ST_IDLE, ST_EXEC} state_type;

   localparam int NW = dvru_pkg::NODE_W;
   localparam int CW = dvru_pkg::COST_W;
   localparam int HW = dvru_pkg::HOP_W;

   state_type state_ff;
   logic [2:0] own_ff;
   logic       round_ff, round_in;
   logic [7:0] idle_ff, idle_in;
   logic [dvru_pkg::NODES-1:0] vld_ff;

   logic [1:0] kind_ff;
   logic [2:0] snd_ff, dst_ff;
   logic signed [CW-1:0] cost_ff;
   logic       nb_ff, last_ff;
   logic       snd_vld_ff, dst_vld_ff;
   logic [dvru_pkg::ENTRY_W-1:0] rd_snd_ff, rd_dst_ff;

   logic [dvru_pkg::ENTRY_W-1:0] route_mem [dvru_pkg::NODES];

   logic       rsp_valid_ff;
   logic [2:0] rsp_dest_ff;
   logic signed [CW-1:0] rsp_cost_ff;
   logic signed [HW-1:0] rsp_hop_ff;
   logic       rsp_changed_ff, rsp_round_ff;
   logic [7:0] rsp_idle_ff;

   logic req_acc, exec_done, wr_en;
   logic dst_ok, snd_ok, repl;
   logic signed [CW-1:0] s_cost, d_cost, new_cost, sum_sat, out_cost;
   logic signed [HW-1:0] s_hop, d_hop, new_hop, out_hop;
   logic [CW:0] sum_raw;
   logic rflag;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign exec_done = (state_ff == ST_EXEC) && (!rsp_valid_ff || !rsp_stall);

   assign dst_ok = 32'(dst_ff) < dvru_pkg::NODES;
   assign snd_ok = 32'(snd_ff) < dvru_pkg::NODES;

   // entries never written read as unreachable / unknown
   assign s_cost = snd_vld_ff ? rd_snd_ff[dvru_pkg::ENTRY_W-1:HW] : dvru_pkg::COST_UNREACH;
   assign s_hop  = snd_vld_ff ? rd_snd_ff[HW-1:0] : dvru_pkg::HOP_UNKNOWN;
   assign d_cost = dst_vld_ff ? rd_dst_ff[dvru_pkg::ENTRY_W-1:HW] : dvru_pkg::COST_UNREACH;
   assign d_hop  = dst_vld_ff ? rd_dst_ff[HW-1:0] : dvru_pkg::HOP_UNKNOWN;

   assign sum_raw = {2'b00, cost_ff[CW-2:0]} + {2'b00, s_cost[CW-2:0]};
   assign sum_sat = (sum_raw[CW:CW-1] != 2'b00) ? dvru_pkg::COST_MAX
                                                : CW'(sum_raw);

   always_comb begin
      repl     = 1'b0;
      wr_en    = 1'b0;
      new_cost = d_cost;
      new_hop  = d_hop;
      case (kind_ff)
         dvru_pkg::KIND_LOAD: begin
            wr_en = exec_done && dst_ok;
            if (dst_ff == own_ff) begin
               new_cost = dvru_pkg::COST_SELF;
               new_hop  = dvru_pkg::HOP_SELF;
            end else begin
               new_cost = cost_ff;
               new_hop  = nb_ff ? HW'({1'b0, dst_ff}) : dvru_pkg::HOP_UNKNOWN;
            end
         end
         dvru_pkg::KIND_ADV: begin
            if (dst_ok && snd_ok && !cost_ff[CW-1] && !s_cost[CW-1] &&
                ((d_cost == dvru_pkg::COST_UNREACH) ||
                 ((sum_sat < d_cost) && (d_cost != 16'sd1)))) begin
               repl = 1'b1;
            end
            wr_en    = exec_done && repl;
            new_cost = sum_sat;
            new_hop  = s_hop;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      round_in = round_ff;
      idle_in  = idle_ff;
      rflag    = round_ff;
      if (kind_ff == dvru_pkg::KIND_ADV) begin
         if (repl) begin
            round_in = 1'b1;
            idle_in  = '0;
         end
         rflag = round_in;
         if (last_ff) begin
            if (!round_in && (idle_in != dvru_pkg::IDLE_MAX)) begin
               idle_in = idle_in + 8'd1;
            end
            round_in = 1'b0;
         end
      end
   end

   assign out_cost = !dst_ok ? dvru_pkg::COST_UNREACH :
                     (wr_en ? new_cost : d_cost);
   assign out_hop  = !dst_ok ? dvru_pkg::HOP_UNKNOWN :
                     (wr_en ? new_hop : d_hop);

   // route memory: two registered read ports, one write port
   always_ff @(posedge clock) begin
      if (req_acc) begin
         rd_snd_ff <= route_mem[NW'(req_sender)];
         rd_dst_ff <= route_mem[NW'(req_dest)];
      end
      if (wr_en) begin
         route_mem[NW'(dst_ff)] <= {new_cost, new_hop};
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         kind_ff    <= req_kind;
         snd_ff     <= req_sender;
         dst_ff     <= req_dest;
         cost_ff    <= req_cost;
         nb_ff      <= req_is_neighbour;
         last_ff    <= req_last;
         snd_vld_ff <= (32'(req_sender) < dvru_pkg::NODES) && vld_ff[NW'(req_sender)];
         dst_vld_ff <= (32'(req_dest) < dvru_pkg::NODES) && vld_ff[NW'(req_dest)];
      end
      if (exec_done) begin
         rsp_dest_ff    <= dst_ff;
         rsp_cost_ff    <= out_cost;
         rsp_hop_ff     <= out_hop;
         rsp_changed_ff <= (kind_ff == dvru_pkg::KIND_LOAD) || repl;
         rsp_round_ff   <= rflag;
         rsp_idle_ff    <= idle_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         own_ff       <= '0;
         round_ff     <= 1'b0;
         idle_ff      <= '0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            own_ff <= csr_own_index;
         end
         if (wr_en) begin
            vld_ff[NW'(dst_ff)] <= 1'b1;
         end
         if (exec_done) begin
            round_ff <= round_in;
            idle_ff  <= idle_in;
         end
         if (exec_done) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_acc) begin
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               if (exec_done) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_dest_out      = rsp_dest_ff;
   assign rsp_cost_out      = rsp_cost_ff;
   assign rsp_next_hop      = rsp_hop_ff;
   assign rsp_changed       = rsp_changed_ff;
   assign rsp_round_updated = rsp_round_ff;
   assign rsp_idle_rounds   = rsp_idle_ff;

`ifndef ASSERT_OFF
   a_acc_to_exec: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (state_ff == ST_EXEC))
      else $error("accepted item did not enter execute");

   a_wr_in_exec: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_EXEC) && exec_done)
      else $error("table write outside execute");

   a_repl_clears_idle: assert property (@(posedge clock) disable iff (reset)
      (exec_done && repl) |=> (idle_ff == 8'd0))
      else $error("replacement did not clear idle counter");

   a_last_clears_round: assert property (@(posedge clock) disable iff (reset)
      (exec_done && (kind_ff == dvru_pkg::KIND_ADV) && last_ff) |=> !round_ff)
      else $error("round flag not cleared at round close");

   a_done_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      exec_done |=> rsp_valid)
      else $error("finished item produced no result");
`endif

endmodule

### sim/tb_distance_vector_route_update_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_distance_vector_route_update_unit
// Self-checking bench for the route update unit. Drives link loads, advertised
// vector elements and lookups with random gaps and result back-pressure. A
// local copy of the routing table predicts each result item, which is checked
// field by field in order of arrival.
// ----------------------------------------------------------------------------
module tb_distance_vector_route_update_unit;

   localparam logic [1:0] KIND_SPARE = 2'd3;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 4;

   typedef struct {
      logic [1:0]                          kind;
      logic [2:0]                          sender;
      logic [2:0]                          dest;
      logic signed [dvru_pkg::COST_W-1:0]  cost;
      logic                                is_neighbour;
      logic                                last;
   } route_item_type;

   typedef struct {
      logic [2:0]                          dest;
      logic signed [dvru_pkg::COST_W-1:0]  cost;
      logic signed [dvru_pkg::HOP_W-1:0]   hop;
      logic                                changed;
      logic                                round_updated;
      logic [7:0]                          idle_rounds;
   } route_report_type;

   logic        clock;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_own_index;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_kind;
   logic [2:0]  req_sender;
   logic [2:0]  req_dest;
   logic signed [15:0] req_cost;
   logic        req_is_neighbour;
   logic        req_last;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_dest_out;
   logic signed [15:0] rsp_cost_out;
   logic signed [3:0]  rsp_next_hop;
   logic        rsp_changed;
   logic        rsp_round_updated;
   logic [7:0]  rsp_idle_rounds;

   // table mirror
   logic signed [dvru_pkg::COST_W-1:0] route_cost [dvru_pkg::NODES];
   logic signed [dvru_pkg::HOP_W-1:0]  route_hop  [dvru_pkg::NODES];
   logic                               round_pending;
   logic [7:0]                         idle_count;
   logic [2:0]                         own_node;

   route_report_type pending_reports [$];

   int  cycle_count;
   int  error_count;
   int  stall_left;
   bit  calm;
   int  items_sent, loads_sent, vector_sent, lookups_sent, results_checked;
   int  replaced_count, rounds_closed, idle_peak, settings_used;

   distance_vector_route_update_unit i_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_own_index     (csr_own_index),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_sender        (req_sender),
      .req_dest          (req_dest),
      .req_cost          (req_cost),
      .req_is_neighbour  (req_is_neighbour),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_dest_out      (rsp_dest_out),
      .rsp_cost_out      (rsp_cost_out),
      .rsp_next_hop      (rsp_next_hop),
      .rsp_changed       (rsp_changed),
      .rsp_round_updated (rsp_round_updated),
      .rsp_idle_rounds   (rsp_idle_rounds)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count > CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_reports.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic int draw_wait();
      return calm ? 0 : $urandom_range(0, 3);
   endfunction

   function automatic route_item_type make_item(logic [1:0] kind, logic [2:0] sender,
                                                logic [2:0] dest, logic signed [15:0] cost,
                                                logic nb, logic last);
      route_item_type it;
      it.kind = kind;
      it.sender = sender;
      it.dest = dest;
      it.cost = cost;
      it.is_neighbour = nb;
      it.last = last;
      return it;
   endfunction

   function automatic logic signed [15:0] rand_cost();
      int r;
      r = $urandom_range(0, 15);
      case (r)
         0: return dvru_pkg::COST_UNREACH;
         1: return dvru_pkg::COST_SELF;
         2: return 16'($urandom);
         3: return dvru_pkg::COST_MAX - 16'($urandom_range(0, 3));
         4: return 16'sd1;
         default: return 16'($urandom_range(0, 40));
      endcase
   endfunction

   // Bellman-Ford update of the table mirror; returns the report for dest
   function automatic route_report_type apply_route_item(route_item_type it);
      route_report_type rep;
      int sender_cost;
      int stored;
      int sum;
      int adv;
      rep.changed = 1'b0;
      if (it.kind == dvru_pkg::KIND_LOAD) begin
         if (it.dest == own_node) begin
            route_cost[it.dest] = dvru_pkg::COST_SELF;
            route_hop[it.dest] = dvru_pkg::HOP_SELF;
         end else begin
            route_cost[it.dest] = it.cost;
            route_hop[it.dest] = it.is_neighbour ? {1'b0, it.dest} : dvru_pkg::HOP_UNKNOWN;
         end
         rep.changed = 1'b1;
         rep.round_updated = round_pending;
      end else if (it.kind == dvru_pkg::KIND_ADV) begin
         sender_cost = route_cost[it.sender];
         adv = it.cost;
         if (adv >= 0 && sender_cost >= 0) begin
            sum = adv + sender_cost;
            if (sum > dvru_pkg::COST_MAX) sum = dvru_pkg::COST_MAX;
            stored = route_cost[it.dest];
            if (stored == dvru_pkg::COST_UNREACH || (sum < stored && stored != 1)) begin
               route_cost[it.dest] = 16'(sum);
               route_hop[it.dest] = route_hop[it.sender];
               rep.changed = 1'b1;
               round_pending = 1'b1;
               idle_count = '0;
               replaced_count++;
            end
         end
         rep.round_updated = round_pending;
         if (it.last) begin
            if (!round_pending && idle_count < dvru_pkg::IDLE_MAX) idle_count++;
            round_pending = 1'b0;
            rounds_closed++;
         end
      end else begin
         rep.round_updated = round_pending;
      end
      rep.dest = it.dest;
      rep.cost = route_cost[it.dest];
      rep.hop = route_hop[it.dest];
      rep.idle_rounds = idle_count;
      if (idle_count > idle_peak) idle_peak = idle_count;
      return rep;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("cycle %0d: %s got %0d, expected %0d", cycle_count, what, got, want);
      error_count++;
   endtask

   // Call back to back; drain_routes releases the request channel.
   task automatic send_item(route_item_type it);
      int gap;
      gap = draw_wait();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= it.kind;
      req_sender       <= it.sender;
      req_dest         <= it.dest;
      req_cost         <= it.cost;
      req_is_neighbour <= it.is_neighbour;
      req_last         <= it.last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_reports.push_back(apply_route_item(it));
      items_sent++;
      case (it.kind)
         dvru_pkg::KIND_LOAD: loads_sent++;
         dvru_pkg::KIND_ADV:  vector_sent++;
         default:             lookups_sent++;
      endcase
   endtask

   task automatic drain_routes();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_own_index(logic [2:0] node);
      @(negedge clock);
      csr_valid     <= 1'b1;
      csr_own_index <= node;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      own_node = node;
      settings_used++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // result side back-pressure
   initial begin
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      route_report_type want;
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
            stall_left = draw_wait();
            if (pending_reports.size() == 0) begin
               report_mismatch("unexpected result item, dest", rsp_dest_out, -1);
            end else begin
               want = pending_reports.pop_front();
               results_checked++;
               if (rsp_dest_out !== want.dest)
                  report_mismatch("dest_out", rsp_dest_out, want.dest);
               if (rsp_cost_out !== want.cost)
                  report_mismatch("cost_out", rsp_cost_out, want.cost);
               if (rsp_next_hop !== want.hop)
                  report_mismatch("next_hop", rsp_next_hop, want.hop);
               if (rsp_changed !== want.changed)
                  report_mismatch("changed", rsp_changed, want.changed);
               if (rsp_round_updated !== want.round_updated)
                  report_mismatch("round_updated", rsp_round_updated, want.round_updated);
               if (rsp_idle_rounds !== want.idle_rounds)
                  report_mismatch("idle_rounds", rsp_idle_rounds, want.idle_rounds);
            end
         end
      end
   end

   task automatic test_after_reset();
      send_item(make_item(dvru_pkg::KIND_LOOK, 3'd0, 3'd5, 16'sd0, 1'b0, 1'b0));
      send_item(make_item(KIND_SPARE, 3'd7, 3'd7, dvru_pkg::COST_UNREACH, 1'b1, 1'b1));
      // sender unreachable: ignored, round closes idle
      send_item(make_item(dvru_pkg::KIND_ADV, 3'd2, 3'd3, 16'sd4, 1'b0, 1'b1));
      drain_routes();
   endtask

   task automatic test_link_loads();
      send_item(make_item(dvru_pkg::KIND_LOAD, 3'd0, 3'd0, 16'sd5, 1'b1, 1'b0));
      send_item(make_item(dvru_pkg::KIND_LOAD, 3'd0, 3'd1, 16'sd1, 1'b1, 1'b0));
      send_item(make_item(dvru_pkg::KIND_LOAD, 3'd0, 3'd2, 16'sd3, 1'b1, 1'b0));
      send_item(make_item(dvru_pkg::KIND_LOAD, 3'd0, 3'd3, dvru_pkg::COST_MAX, 1'b0, 1'b0));
      send_item(make_item(dvru_pkg::KIND_LOAD, 3'd0, 3'd4, dvru_pkg::COST_UNREACH,
                          1'b0, 1'b0));
      send_item(make_item(dvru_pkg::KIND_LOAD, 3'd0, 3'd5, 16'sd1, 1'b0, 1'b0));
      drain_routes();
   endtask

   task automatic test_vector_rules();
      send_item(make_item(dvru_pkg::KIND_ADV, 3'd2, 3'd6, 16'sd0, 1'b0, 1'b0));
      send_item(make_item(dvru_pkg::KIND_ADV, 3'd2, 3'd3, dvru_pkg::COST_MAX, 1'b0, 1'b0));
      send_item(make_item(dvru_pkg::KIND_ADV, 3'd2, 3'd3, 16'sd10, 1'b0, 1'b0));
      // stored cost of one is kept
      send_item(make_item(dvru_pkg::KIND_ADV, 3'd2, 3'd5, 16'sd0, 1'b0, 1'b0));
      send_item(make_item(dvru_pkg::KIND_ADV, 3'd2, 3'd4, dvru_pkg::COST_UNREACH,
                          1'b0, 1'b0));
      send_item(make_item(dvru_pkg::KIND_ADV, 3'd2, 3'd4, dvru_pkg::COST_SELF, 1'b0, 1'b0));
      send_item(make_item(dvru_pkg::KIND_ADV, 3'd2, 3'd4, 16'sh8000, 1'b0, 1'b0));
      // sender is self
      send_item(make_item(dvru_pkg::KIND_ADV, 3'd0, 3'd4, 16'sd1, 1'b0, 1'b0));
      // saturating sum
      send_item(make_item(dvru_pkg::KIND_ADV, 3'd1, 3'd4, dvru_pkg::COST_MAX, 1'b0, 1'b1));
      send_item(make_item(dvru_pkg::KIND_ADV, 3'd1, 3'd0, 16'sd0, 1'b0, 1'b1));
      send_item(make_item(dvru_pkg::KIND_LOAD, 3'd0, 3'd1, dvru_pkg::COST_MAX, 1'b1, 1'b0));
      send_item(make_item(dvru_pkg::KIND_ADV, 3'd1, 3'd2, dvru_pkg::COST_MAX, 1'b1, 1'b1));
      drain_routes();
   endtask

   task automatic test_own_index();
      write_own_index(3'd7);
      send_item(make_item(dvru_pkg::KIND_LOAD, 3'd0, 3'd7, 16'sd9, 1'b1, 1'b0));
      send_item(make_item(dvru_pkg::KIND_LOAD, 3'd0, 3'd0, 16'sd2, 1'b1, 1'b0));
      drain_routes();
   endtask

   task automatic test_idle_saturation();
      repeat (262) begin
         send_item(make_item(dvru_pkg::KIND_ADV, 3'($urandom), 3'($urandom),
                             dvru_pkg::COST_UNREACH, 1'($urandom), 1'b1));
      end
      drain_routes();
   endtask

   task automatic send_link_loads();
      int n;
      logic signed [15:0] c;
      n = $urandom_range(1, 4);
      repeat (n) begin
         c = ($urandom_range(0, 3) == 0) ? rand_cost() : 16'($urandom_range(1, 20));
         send_item(make_item(dvru_pkg::KIND_LOAD, 3'($urandom), 3'($urandom), c,
                             ($urandom_range(0, 4) != 0), 1'($urandom)));
      end
   endtask

   task automatic send_vector();
      logic [2:0] src;
      logic [2:0] first;
      int len;
      logic fin;
      src = 3'($urandom);
      first = 3'($urandom);
      len = $urandom_range(1, dvru_pkg::NODES);
      for (int i = 0; i < len; i++) begin
         fin = (i == len - 1);
         if ($urandom_range(0, 9) == 0) fin = ~fin;
         send_item(make_item(dvru_pkg::KIND_ADV, src, 3'(first + i), rand_cost(),
                             1'($urandom), fin));
      end
   endtask

   task automatic test_random_traffic();
      logic [2:0] settings [8];
      int phase_items;
      int pick;
      settings = '{3'd0, 3'd7, 3'd3, 3'd7, 3'd0, 3'd5, 3'($urandom), 3'($urandom)};
      for (int p = 0; p < 8; p++) begin
         write_own_index(settings[p]);
         phase_items = items_sent;
         while (items_sent - phase_items < 165) begin
            calm = ($urandom_range(0, 5) == 0);
            pick = $urandom_range(0, 11);
            if (pick < 3) begin
               send_link_loads();
            end else if (pick < 10) begin
               send_vector();
            end else if (pick == 10) begin
               send_item(make_item(2'($urandom_range(2, 3)), 3'($urandom), 3'($urandom),
                                   16'($urandom), 1'($urandom), 1'($urandom)));
            end else begin
               send_item(make_item(2'($urandom), 3'($urandom), 3'($urandom),
                                   16'($urandom), 1'($urandom), 1'($urandom)));
            end
         end
         calm = 1'b0;
         drain_routes();
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_own_index = '0;
      req_valid = 1'b0;
      req_kind = dvru_pkg::KIND_LOOK;
      req_sender = '0;
      req_dest = '0;
      req_cost = '0;
      req_is_neighbour = 1'b0;
      req_last = 1'b0;
      rsp_stall = 1'b0;
      stall_left = 0;
      calm = 1'b0;
      cycle_count = 0;
      error_count = 0;
      for (int i = 0; i < dvru_pkg::NODES; i++) begin
         route_cost[i] = dvru_pkg::COST_UNREACH;
         route_hop[i] = dvru_pkg::HOP_UNKNOWN;
      end
      round_pending = 1'b0;
      idle_count = '0;
      own_node = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_after_reset();
      test_link_loads();
      test_vector_rules();
      test_own_index();
      test_idle_saturation();
      test_random_traffic();

      if (pending_reports.size() != 0)
         report_mismatch("results never received", 0, pending_reports.size());
      $display("%0d items: %0d loads, %0d vector elements, %0d lookups; %0d results checked",
               items_sent, loads_sent, vector_sent, lookups_sent, results_checked);
      $display("%0d routes replaced, %0d rounds closed, idle count peak %0d, %0d own-index writes",
               replaced_count, rounds_closed, idle_peak, settings_used);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
